// ----- hw/rtl/rcc_pkg.sv -----
// Shared types and constants for the recycling chunk cache.
`timescale 1ns / 1ps
package rcc_pkg;
  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int ADDRESS_BITS_DEF  = 48;
  localparam int OUT_AW            = 48;
  localparam int SIZE_W            = 32;
  localparam int MAX_RELEASE       = 32;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_ADOPT  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_SHRINK = 3'd3;
  localparam logic [2:0] OP_REPORT = 3'd4;

  localparam logic [3:0] ST_HIT      = 4'd0;
  localparam logic [3:0] ST_MISS     = 4'd1;
  localparam logic [3:0] ST_REJECT   = 4'd2;
  localparam logic [3:0] ST_ADOPTED  = 4'd3;
  localparam logic [3:0] ST_FULL     = 4'd4;
  localparam logic [3:0] ST_FREED    = 4'd5;
  localparam logic [3:0] ST_NOTFOUND = 4'd6;
  localparam logic [3:0] ST_RELEASED = 4'd7;
  localparam logic [3:0] ST_NONE     = 4'd8;
  localparam logic [3:0] ST_REPORT   = 4'd9;

  localparam logic [1:0] CFG_MIN  = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_BACK = 2'd2;

  localparam logic [15:0] TOL_ONE   = 16'd256;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              valid;
    logic              used;
  } meta_t;
endpackage

// ----- hw/rtl/recycling_chunk_cache_top.sv -----
// Top level of the recycling chunk cache: ring of slot cells and head controller.
`timescale 1ns / 1ps
// Every command keeps busy high through a setup step for the tolerance product, one full
// rotation of the slot ring past the head and a write-back step; start is taken only
// while idle. Result words appear on out_valid for one cycle each and cannot be held off;
// shrink releases come out while the ring rotates, the final word of every command
// carrying out_last. The slot table needs no clearing pass after reset. cfg_ready is
// always high.
module recycling_chunk_cache_top #(
  parameter int TABLE_ENTRIES = rcc_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDRESS_BITS  = rcc_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_request_size,
  input  logic [47:0] in_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [47:0] out_chunk_address,
  output logic [31:0] out_chunk_size,
  output logic [6:0]  out_chunk_count,
  output logic [47:0] out_bytes_used,
  output logic [47:0] out_bytes_held,
  output logic        out_last
);
  localparam int EW = (ADDRESS_BITS < rcc_pkg::OUT_AW) ? ADDRESS_BITS : rcc_pkg::OUT_AW;
  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(N);

  logic [EW-1:0]  c_addr [N];
  rcc_pkg::meta_t c_meta [N];
  logic [EW-1:0]  feed_addr, wr_addr, o_addr;
  rcc_pkg::meta_t feed_meta, wr_meta;
  logic           shift_en, wr_en;
  logic [IW-1:0]  wr_idx;

  assign cfg_ready = 1'b1;

  rcc_ctrl #(.N(N), .AW(EW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .op(in_op), .req(in_request_size), .addr(in_address[EW-1:0]),
    .cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .head_addr(c_addr[0]), .head_meta(c_meta[0]),
    .feed_addr(feed_addr), .feed_meta(feed_meta), .shift_en(shift_en),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_addr(wr_addr), .wr_meta(wr_meta),
    .out_valid(out_valid), .out_status(out_status), .out_addr(o_addr),
    .out_size(out_chunk_size), .out_count(out_chunk_count),
    .out_used(out_bytes_used), .out_held(out_bytes_held), .out_last(out_last)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [EW-1:0]  nb_addr;
    rcc_pkg::meta_t nb_meta;
    if (i == N - 1) begin : g_tail
      assign nb_addr = feed_addr;
      assign nb_meta = feed_meta;
    end else begin : g_mid
      assign nb_addr = c_addr[i+1];
      assign nb_meta = c_meta[i+1];
    end
    rcc_cell #(.AW(EW)) u_cell (
      .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
      .nb_addr(nb_addr), .nb_meta(nb_meta),
      .wr_en(wr_en && wr_idx == IW'(i)), .wr_addr(wr_addr), .wr_meta(wr_meta),
      .addr_o(c_addr[i]), .meta_o(c_meta[i])
    );
  end

  always_comb begin
    out_chunk_address = '0;
    out_chunk_address[EW-1:0] = o_addr;
  end

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("word after last");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("command not taken");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word after reset");
endmodule

// ----- hw/rtl/rcc_cell.sv -----
// One table slot of the rotating chunk ring.
`timescale 1ns / 1ps
module rcc_cell #(
  parameter int AW = rcc_pkg::ADDRESS_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic [AW-1:0]  nb_addr,
  input  rcc_pkg::meta_t nb_meta,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  rcc_pkg::meta_t wr_meta,
  output logic [AW-1:0]  addr_o,
  output rcc_pkg::meta_t meta_o
);
  logic [AW-1:0]  addr_r;
  rcc_pkg::meta_t meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
      meta_r.used  <= 1'b0;
    end else if (wr_en) begin
      addr_r <= wr_addr;
      meta_r <= wr_meta;
    end else if (shift_en) begin
      addr_r <= nb_addr;
      meta_r <= nb_meta;
    end
  end

  assign addr_o = addr_r;
  assign meta_o = meta_r;
endmodule

// ----- hw/rtl/rcc_ctrl.sv -----
// Head controller: config, scan of the ring, write-back and result words.
`timescale 1ns / 1ps
module rcc_ctrl #(
  parameter int N  = rcc_pkg::TABLE_ENTRIES_DEF,
  parameter int AW = rcc_pkg::ADDRESS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            op,
  input  logic [31:0]           req,
  input  logic [AW-1:0]         addr,
  input  logic                  cfg_wr,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [AW-1:0]         head_addr,
  input  rcc_pkg::meta_t        head_meta,
  output logic [AW-1:0]         feed_addr,
  output rcc_pkg::meta_t        feed_meta,
  output logic                  shift_en,
  output logic                  wr_en,
  output logic [$clog2(N)-1:0]  wr_idx,
  output logic [AW-1:0]         wr_addr,
  output rcc_pkg::meta_t        wr_meta,
  output logic                  out_valid,
  output logic [3:0]            out_status,
  output logic [AW-1:0]         out_addr,
  output logic [31:0]           out_size,
  output logic [6:0]            out_count,
  output logic [47:0]           out_used,
  output logic [47:0]           out_held,
  output logic                  out_last
);
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0]    state_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   min_r;
  logic [15:0]   tol_r;
  logic          back_r;
  logic [2:0]    op_r;
  logic [31:0]   req_r;
  logic [AW-1:0] a_r;
  logic [31:0]   need_r;
  logic [39:0]   limit_r;
  logic          hit_v_r, match_v_r, slot_v_r, pend_v_r;
  logic [IW-1:0] hit_idx_r, match_idx_r, slot_idx_r;
  logic [31:0]   hit_size_r, match_size_r, pend_size_r;
  logic [AW-1:0] hit_addr_r, pend_addr_r;
  logic          match_used_r;
  logic [5:0]    rel_cnt_r;
  logic [6:0]    cnt_valid_r;
  logic [47:0]   used_sum_r, held_sum_r;

  logic [IW-1:0] idx;
  logic [31:0]   need;
  logic [15:0]   tol_eff;
  logic [47:0]   prod;
  logic          cand, rel, is_match;
  logic [48:0]   held_add, used_add;

  assign busy = (state_r != S_IDLE);
  assign idx = cnt_r[IW-1:0];
  assign need = (req_r < min_r) ? min_r : req_r;
  assign tol_eff = (tol_r < rcc_pkg::TOL_ONE) ? rcc_pkg::TOL_ONE : tol_r;
  assign prod = 48'(need) * 48'(tol_eff);
  assign cand = head_meta.valid && !head_meta.used && head_meta.size >= need_r
                && {8'd0, head_meta.size} <= limit_r;
  assign rel = (op_r == rcc_pkg::OP_SHRINK) && head_meta.valid && !head_meta.used
               && rel_cnt_r < 6'(rcc_pkg::MAX_RELEASE);
  assign is_match = head_meta.valid && head_addr == a_r;
  assign held_add = {1'b0, held_sum_r} + 49'(head_meta.size);
  assign used_add = {1'b0, used_sum_r} + 49'(head_meta.size);

  assign shift_en = (state_r == S_SCAN);
  always_comb begin
    feed_addr = head_addr;
    feed_meta = head_meta;
    if (rel) feed_meta.valid = 1'b0;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = match_idx_r;
    wr_addr = a_r;
    wr_meta.size = req_r;
    wr_meta.valid = 1'b1;
    wr_meta.used = 1'b1;
    if (state_r == S_FIN) begin
      case (op_r)
        rcc_pkg::OP_ALLOC: begin
          wr_en = (req_r != 32'd0) && hit_v_r;
          wr_idx = hit_idx_r;
          wr_addr = hit_addr_r;
          wr_meta.size = hit_size_r;
        end
        rcc_pkg::OP_ADOPT: begin
          wr_en = (a_r != '0) && (match_v_r || slot_v_r);
          wr_idx = match_v_r ? match_idx_r : slot_idx_r;
        end
        rcc_pkg::OP_FREE: begin
          wr_en = (a_r != '0) && match_v_r && match_used_r;
          wr_meta.size = match_size_r;
          wr_meta.used = 1'b0;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      min_r <= 32'd0;
      tol_r <= rcc_pkg::TOL_ONE;
      back_r <= 1'b1;
      out_valid <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index)
          rcc_pkg::CFG_MIN:  min_r <= cfg_data;
          rcc_pkg::CFG_TOL:  tol_r <= cfg_data[15:0];
          rcc_pkg::CFG_BACK: back_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            req_r <= req;
            a_r <= addr;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          need_r <= need;
          limit_r <= prod[47:8];
          hit_v_r <= 1'b0;
          match_v_r <= 1'b0;
          slot_v_r <= 1'b0;
          pend_v_r <= 1'b0;
          rel_cnt_r <= 6'd0;
          cnt_valid_r <= 7'd0;
          used_sum_r <= 48'd0;
          held_sum_r <= 48'd0;
          cnt_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cand && (!hit_v_r || head_meta.size < hit_size_r)) begin
            hit_v_r <= 1'b1;
            hit_idx_r <= idx;
            hit_size_r <= head_meta.size;
            hit_addr_r <= head_addr;
          end
          if (is_match && !match_v_r) begin
            match_v_r <= 1'b1;
            match_idx_r <= idx;
            match_used_r <= head_meta.used;
            match_size_r <= head_meta.size;
          end
          if (!head_meta.valid && !slot_v_r) begin
            slot_v_r <= 1'b1;
            slot_idx_r <= idx;
          end
          if (head_meta.valid) begin
            cnt_valid_r <= cnt_valid_r + 7'd1;
            held_sum_r <= held_add[48] ? rcc_pkg::BYTES_MAX : held_add[47:0];
            if (head_meta.used)
              used_sum_r <= used_add[48] ? rcc_pkg::BYTES_MAX : used_add[47:0];
          end
          if (rel) begin
            rel_cnt_r <= rel_cnt_r + 6'd1;
            pend_v_r <= 1'b1;
            pend_addr_r <= head_addr;
            pend_size_r <= head_meta.size;
            if (pend_v_r) begin
              out_valid <= 1'b1;
              out_status <= rcc_pkg::ST_RELEASED;
              out_addr <= pend_addr_r;
              out_size <= pend_size_r;
              out_count <= 7'd0;
              out_used <= 48'd0;
              out_held <= 48'd0;
              out_last <= 1'b0;
            end
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(N - 1)) state_r <= S_FIN;
        end
        default: begin
          out_valid <= 1'b1;
          out_last <= 1'b1;
          out_status <= rcc_pkg::ST_REJECT;
          out_addr <= '0;
          out_size <= 32'd0;
          out_count <= 7'd0;
          out_used <= 48'd0;
          out_held <= 48'd0;
          case (op_r)
            rcc_pkg::OP_ALLOC: begin
              if (req_r != 32'd0) begin
                if (hit_v_r) begin
                  out_status <= rcc_pkg::ST_HIT;
                  out_addr <= hit_addr_r;
                  out_size <= hit_size_r;
                end else begin
                  out_status <= back_r ? rcc_pkg::ST_MISS : rcc_pkg::ST_REJECT;
                  out_size <= need_r;
                end
              end
            end
            rcc_pkg::OP_ADOPT: begin
              if (a_r != '0) begin
                out_status <= (match_v_r || slot_v_r) ? rcc_pkg::ST_ADOPTED
                                                      : rcc_pkg::ST_FULL;
                out_addr <= a_r;
                out_size <= req_r;
              end
            end
            rcc_pkg::OP_FREE: begin
              out_addr <= a_r;
              if (a_r != '0 && match_v_r && match_used_r) begin
                out_status <= rcc_pkg::ST_FREED;
                out_size <= match_size_r;
              end else begin
                out_status <= rcc_pkg::ST_NOTFOUND;
              end
            end
            rcc_pkg::OP_SHRINK: begin
              if (pend_v_r) begin
                out_status <= rcc_pkg::ST_RELEASED;
                out_addr <= pend_addr_r;
                out_size <= pend_size_r;
              end else begin
                out_status <= rcc_pkg::ST_NONE;
              end
            end
            rcc_pkg::OP_REPORT: begin
              out_status <= rcc_pkg::ST_REPORT;
              out_count <= cnt_valid_r;
              out_used <= used_sum_r;
              out_held <= held_sum_r;
            end
            default: out_status <= rcc_pkg::ST_REJECT;
          endcase
          pend_v_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
